// ===== rtl/core/lsb_stego_frame_extractor_top_assert.svh =====
// Assertion macros for the LSB frame extractor top level.
// No dependencies; included by lsb_stego_frame_extractor_top.sv.
`ifndef LSB_STEGO_FRAME_EXTRACTOR_TOP_ASSERT_SVH
`define LSB_STEGO_FRAME_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lse_pkg.sv =====
// Shared types and constants for the LSB frame extractor.
// No dependencies; used by lsb_stego_frame_extractor_top.sv.
package lse_pkg;

    localparam int WORD_BITS = 32;
    localparam int CHAR_BITS = 8;
    localparam int CFG_W     = 8;
    localparam int CNT_W     = 5;               // counts 0..31 bits
    localparam int REM_W     = WORD_BITS - 1;   // positive lengths only
    localparam int IDX_W     = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_HEADER_SKIP = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAGIC_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_EXT_LIMIT   = 2'd2;

    localparam logic [CFG_W-1:0] HEADER_SKIP_RST = 8'd54;
    localparam logic [CFG_W-1:0] MAGIC_LIMIT_RST = 8'd19;
    localparam logic [CFG_W-1:0] EXT_LIMIT_RST   = 8'd10;

    // Result kinds
    localparam logic [2:0] KIND_MAGIC_CHAR = 3'd0;
    localparam logic [2:0] KIND_EXT_CHAR   = 3'd1;
    localparam logic [2:0] KIND_DATA       = 3'd2;
    localparam logic [2:0] KIND_MAGIC_LEN  = 3'd3;
    localparam logic [2:0] KIND_EXT_LEN    = 3'd4;
    localparam logic [2:0] KIND_SECRET_LEN = 3'd5;
    localparam logic [2:0] KIND_ERROR      = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_EXT   = 2'd2;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_MLEN  = 3'd1,
        PH_MAGIC = 3'd2,
        PH_ELEN  = 3'd3,
        PH_EXT   = 3'd4,
        PH_SSIZE = 3'd5,
        PH_DATA  = 3'd6,
        PH_IDLE  = 3'd7
    } phase_t;

endpackage

// ===== rtl/core/lsb_stego_frame_extractor_top.sv =====
// LSB frame extractor: pulls hidden length words and characters out of bit 0
// of carrier image bytes. Depends on lse_pkg.sv and the _assert.svh macros.
//
//  channel | signals                              | direction | beat
//  --------+--------------------------------------+-----------+--------------------------
//  input   | in_valid, in_stall, image_byte, sof  | in        | one carrier byte
//  output  | out_valid, out_stall, decoded_byte.. | out       | one decoded word or char
//  config  | cfg_valid, cfg_ready, index, data    | in        | one register write
//
// One image byte per cycle while in_stall is low; a taken byte passes through
// the input register, then the parse step, into the result register.
// The parse step holds one shift, one 31-bit compare and one decrement.
// rst_n clears the parser and loads the register defaults; no clearing pass.
// in_stall rises only when the input register holds a beat and the result
// register is full and stalled. cfg_ready is always high.
`include "lsb_stego_frame_extractor_top_assert.svh"

module lsb_stego_frame_extractor_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [7:0]                              image_byte,
    input  logic                                    start_of_image,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [7:0]                              decoded_byte,
    output logic [2:0]                              item_kind,
    output logic signed [31:0]                      length_value,
    output logic [1:0]                              status,
    output logic                                    message_end,
    // configuration
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lse_pkg::IDX_W-1:0]               cfg_index,
    input  logic [lse_pkg::CFG_W-1:0]               cfg_data
);

    // ---------------- configuration registers ----------------
    logic [lse_pkg::CFG_W-1:0] header_skip_reg;
    logic [lse_pkg::CFG_W-1:0] magic_limit_reg;
    logic [lse_pkg::CFG_W-1:0] ext_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg <= lse_pkg::HEADER_SKIP_RST;
            magic_limit_reg <= lse_pkg::MAGIC_LIMIT_RST;
            ext_limit_reg   <= lse_pkg::EXT_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lse_pkg::CFG_HEADER_SKIP: header_skip_reg <= cfg_data;
                lse_pkg::CFG_MAGIC_LIMIT: magic_limit_reg <= cfg_data;
                lse_pkg::CFG_EXT_LIMIT:   ext_limit_reg   <= cfg_data;
                default:                  ;   // unmapped index: dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic in_valid_reg;
    logic bit_reg;       // only bit 0 of the carrier byte matters
    logic sof_reg;
    logic adv;           // result register can take a new value

    assign adv      = !out_valid || !out_stall;
    assign in_stall = in_valid_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            bit_reg <= image_byte[0];
            sof_reg <= start_of_image;
        end
    end

    // ---------------- parser state ----------------
    lse_pkg::phase_t                 phase_reg, phase_next;
    logic [lse_pkg::WORD_BITS-2:0]   shift_reg, shift_next;   // bits gathered so far
    logic [lse_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lse_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [lse_pkg::CFG_W-1:0]       hdr_reg, hdr_next;

    // start_of_image wipes the parser before this byte is looked at
    lse_pkg::phase_t                 ph_cur, ph_eff;
    logic [lse_pkg::WORD_BITS-2:0]   shift_cur;
    logic [lse_pkg::CNT_W-1:0]       cnt_cur;
    logic [lse_pkg::REM_W-1:0]       rem_cur, rem_dec;
    logic [lse_pkg::CFG_W-1:0]       hdr_cur;

    logic                            step;
    logic                            skipping;
    logic                            is_word;
    logic                            done;
    logic                            produce;
    logic                            rem_last;
    logic [lse_pkg::WORD_BITS-1:0]   w;
    logic [lse_pkg::CFG_W-1:0]       limit_sel;
    logic                            len_ok;
    logic                            size_end;

    assign step      = in_valid_reg && adv;
    assign ph_cur    = sof_reg ? lse_pkg::PH_SKIP : phase_reg;
    assign shift_cur = sof_reg ? '0 : shift_reg;
    assign cnt_cur   = sof_reg ? '0 : cnt_reg;
    assign rem_cur   = sof_reg ? '0 : rem_reg;
    assign hdr_cur   = sof_reg ? '0 : hdr_reg;

    assign skipping  = (ph_cur == lse_pkg::PH_SKIP) && (hdr_cur < header_skip_reg);
    assign ph_eff    = (ph_cur == lse_pkg::PH_SKIP) ? lse_pkg::PH_MLEN : ph_cur;
    assign is_word   = (ph_eff == lse_pkg::PH_MLEN) || (ph_eff == lse_pkg::PH_ELEN) ||
                       (ph_eff == lse_pkg::PH_SSIZE);
    assign w         = {shift_cur, bit_reg};
    assign done      = is_word ? (cnt_cur == lse_pkg::CNT_W'(lse_pkg::WORD_BITS - 1))
                               : (cnt_cur == lse_pkg::CNT_W'(lse_pkg::CHAR_BITS - 1));
    assign produce   = in_valid_reg && (ph_cur != lse_pkg::PH_IDLE) && !skipping && done;

    assign rem_dec   = rem_cur - lse_pkg::REM_W'(1);
    assign rem_last  = (rem_cur == lse_pkg::REM_W'(1));

    // length accepted when positive and no larger than the limit
    assign limit_sel = (ph_eff == lse_pkg::PH_MLEN) ? magic_limit_reg : ext_limit_reg;
    assign len_ok    = !w[lse_pkg::WORD_BITS-1] && (w != '0) &&
                       (w[lse_pkg::WORD_BITS-2:0] <= lse_pkg::REM_W'(limit_sel));
    assign size_end  = w[lse_pkg::WORD_BITS-1] || (w == '0);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        hdr_next   = hdr_reg;
        if (step)
        begin
            phase_next = ph_cur;
            shift_next = shift_cur;
            cnt_next   = cnt_cur;
            rem_next   = rem_cur;
            hdr_next   = hdr_cur;
            if (ph_cur == lse_pkg::PH_IDLE)
            begin
                // message over: byte ignored
            end
            else if (skipping)
            begin
                hdr_next = hdr_cur + lse_pkg::CFG_W'(1);
            end
            else if (!done)
            begin
                phase_next = ph_eff;
                shift_next = w[lse_pkg::WORD_BITS-2:0];
                cnt_next   = cnt_cur + lse_pkg::CNT_W'(1);
            end
            else
            begin
                shift_next = '0;
                cnt_next   = '0;
                case (ph_eff)
                    lse_pkg::PH_MLEN:
                    begin
                        phase_next = len_ok ? lse_pkg::PH_MAGIC : lse_pkg::PH_IDLE;
                        rem_next   = w[lse_pkg::WORD_BITS-2:0];
                    end
                    lse_pkg::PH_MAGIC:
                    begin
                        rem_next   = rem_dec;
                        phase_next = rem_last ? lse_pkg::PH_ELEN : lse_pkg::PH_MAGIC;
                    end
                    lse_pkg::PH_ELEN:
                    begin
                        phase_next = len_ok ? lse_pkg::PH_EXT : lse_pkg::PH_IDLE;
                        rem_next   = w[lse_pkg::WORD_BITS-2:0];
                    end
                    lse_pkg::PH_EXT:
                    begin
                        rem_next   = rem_dec;
                        phase_next = rem_last ? lse_pkg::PH_SSIZE : lse_pkg::PH_EXT;
                    end
                    lse_pkg::PH_SSIZE:
                    begin
                        phase_next = size_end ? lse_pkg::PH_IDLE : lse_pkg::PH_DATA;
                        rem_next   = w[lse_pkg::WORD_BITS-2:0];
                    end
                    lse_pkg::PH_DATA:
                    begin
                        rem_next   = rem_dec;
                        phase_next = rem_last ? lse_pkg::PH_IDLE : lse_pkg::PH_DATA;
                    end
                    default:
                    begin
                        phase_next = ph_eff;
                    end
                endcase
            end
        end
    end

    // result fields for a completed word or char
    logic [7:0]  res_byte;
    logic [2:0]  res_kind;
    logic [31:0] res_len;
    logic [1:0]  res_status;
    logic        res_end;

    always_comb
    begin
        res_byte   = '0;
        res_kind   = lse_pkg::KIND_DATA;
        res_len    = '0;
        res_status = lse_pkg::ST_OK;
        res_end    = 1'b0;
        case (ph_eff)
            lse_pkg::PH_MLEN:
            begin
                res_len = w;
                if (len_ok)
                begin
                    res_kind = lse_pkg::KIND_MAGIC_LEN;
                end
                else
                begin
                    res_kind   = lse_pkg::KIND_ERROR;
                    res_status = lse_pkg::ST_BAD_MAGIC;
                    res_end    = 1'b1;
                end
            end
            lse_pkg::PH_MAGIC:
            begin
                res_kind = lse_pkg::KIND_MAGIC_CHAR;
                res_byte = w[7:0];
            end
            lse_pkg::PH_ELEN:
            begin
                res_len = w;
                if (len_ok)
                begin
                    res_kind = lse_pkg::KIND_EXT_LEN;
                end
                else
                begin
                    res_kind   = lse_pkg::KIND_ERROR;
                    res_status = lse_pkg::ST_BAD_EXT;
                    res_end    = 1'b1;
                end
            end
            lse_pkg::PH_EXT:
            begin
                res_kind = lse_pkg::KIND_EXT_CHAR;
                res_byte = w[7:0];
            end
            lse_pkg::PH_SSIZE:
            begin
                res_kind = lse_pkg::KIND_SECRET_LEN;
                res_len  = w;
                res_end  = size_end;
            end
            lse_pkg::PH_DATA:
            begin
                res_kind = lse_pkg::KIND_DATA;
                res_byte = w[7:0];
                res_end  = rem_last;
            end
            default:
            begin
                res_kind = lse_pkg::KIND_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lse_pkg::PH_SKIP;
            shift_reg <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            hdr_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            hdr_reg   <= hdr_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= step && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            decoded_byte <= res_byte;
            item_kind    <= res_kind;
            length_value <= res_len;
            status       <= res_status;
            message_end  <= res_end;
        end
    end

    // ---------------- assertions ----------------
    `LSE_ASSERT_IMPL(a_error_ends, clk, rst_n,
        out_valid && (item_kind == lse_pkg::KIND_ERROR),
        message_end && (status != lse_pkg::ST_OK),
        "error beat without end flag or error status")

    `LSE_ASSERT_IMPL(a_status_only_on_error, clk, rst_n,
        out_valid && (status != lse_pkg::ST_OK),
        item_kind == lse_pkg::KIND_ERROR,
        "non-ok status on a regular beat")

    `LSE_ASSERT_NEXT(a_idle_silent, clk, rst_n,
        step && !sof_reg && (phase_reg == lse_pkg::PH_IDLE),
        !out_valid,
        "result produced after message end")

    `LSE_ASSERT_IMPL(a_char_count_range, clk, rst_n,
        (phase_reg == lse_pkg::PH_MAGIC) || (phase_reg == lse_pkg::PH_EXT) ||
        (phase_reg == lse_pkg::PH_DATA),
        cnt_reg < lse_pkg::CNT_W'(lse_pkg::CHAR_BITS),
        "bit count past a character in a char phase")

endmodule
